[sv/wfd_pkg.sv]
// shared types and constants for the wait-for deadlock detector
package wfd_pkg;

  localparam int SLOT_W           = 4;
  localparam int REQ_W            = 2;
  localparam int THREAD_COUNT_DEF = 16;

  typedef enum logic [REQ_W-1:0] {
    REQ_CHECK  = 2'd0,
    REQ_RECORD = 2'd1,
    REQ_REMOVE = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_e;

  // table edit command from the sequencer
  typedef struct packed {
    logic              set;
    logic              clr;
    logic              clr_all;
    logic [SLOT_W-1:0] target;
  } wfd_cmd_t;

endpackage

[sv/wfd_table.sv]
// wait-for table: valid flops plus target memory with registered read
module wfd_table import wfd_pkg::*; #(
  parameter int ThreadCount = THREAD_COUNT_DEF,
  localparam int IdxW = (ThreadCount > 1) ? $clog2(ThreadCount) : 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  wfd_cmd_t          cmd_i,
  input  logic [IdxW-1:0]   wr_idx_i,
  input  logic [IdxW-1:0]   rd_idx_i,
  output logic [SLOT_W-1:0] rd_target_o,
  input  logic [IdxW-1:0]   vld_idx_i,
  output logic              vld_o
);

  logic [ThreadCount-1:0] valid_q;
  logic [SLOT_W-1:0]      target_mem [ThreadCount];
  logic [SLOT_W-1:0]      rd_target_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (cmd_i.clr_all) begin
      valid_q <= '0;
    end else if (cmd_i.set) begin
      valid_q[wr_idx_i] <= 1'b1;
    end else if (cmd_i.clr) begin
      valid_q[wr_idx_i] <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.set) begin
      target_mem[wr_idx_i] <= cmd_i.target;
    end
    rd_target_q <= target_mem[rd_idx_i];
  end

  assign rd_target_o = rd_target_q;
  assign vld_o       = valid_q[vld_idx_i];

endmodule

[sv/wait_for_deadlock_detector_core.sv]
// wait-for deadlock detector top level: request sequencer and chain walk
// edit requests (record, remove, clear) give their result in the cycle after accept
// check: walks the holder's chain, visiting at most ThreadCount entries before its result
// throughput: one item at a time; the chain walk reads one table entry per cycle
// reset: all waits cleared, sequencer idle; results cannot be stalled by the receiver
module wait_for_deadlock_detector_core import wfd_pkg::*; #(
  parameter int ThreadCount = THREAD_COUNT_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [REQ_W-1:0]  req_type_i,
  input  logic [SLOT_W-1:0] requester_i,
  input  logic [SLOT_W-1:0] holder_i,
  output logic              result_valid_o,
  output logic              deadlock_o
);

  localparam int IdxW = (ThreadCount > 1) ? $clog2(ThreadCount) : 1;
  localparam int ExtW = (IdxW > SLOT_W) ? IdxW : SLOT_W;
  localparam int CntW = IdxW;

  typedef enum logic {
    ST_IDLE,
    ST_WALK
  } state_e;

  state_e                 state_q;
  logic [SLOT_W-1:0]      cur_q;
  logic [SLOT_W-1:0]      req_q;
  logic [CntW-1:0]        cnt_q;
  logic [ThreadCount-1:0] seen_q;
  logic                   done_q;
  logic                   dl_q;

  wfd_cmd_t          cmd;
  logic [IdxW-1:0]   wr_idx;
  logic [IdxW-1:0]   rd_idx;
  logic [IdxW-1:0]   cur_idx;
  logic [SLOT_W-1:0] rd_target;
  logic              cur_vld;
  logic              accept;
  logic              wr_ok;
  logic              cur_ok;
  logic [ExtW-1:0]   req_ext;
  logic [ExtW-1:0]   hold_ext;
  logic [ExtW-1:0]   cur_ext;
  logic [ExtW-1:0]   tgt_ext;

  assign accept = start && !busy;

  // slot numbers widened so they index or range-check at any table depth
  assign req_ext  = ExtW'(requester_i);
  assign hold_ext = ExtW'(holder_i);
  assign cur_ext  = ExtW'(cur_q);
  assign tgt_ext  = ExtW'(rd_target);
  assign wr_ok    = {1'b0, req_ext} < (ExtW+1)'(ThreadCount);
  assign cur_ok   = {1'b0, cur_ext} < (ExtW+1)'(ThreadCount);
  assign wr_idx   = req_ext[IdxW-1:0];
  assign cur_idx  = cur_ext[IdxW-1:0];
  assign rd_idx   = (state_q == ST_WALK) ? tgt_ext[IdxW-1:0] : hold_ext[IdxW-1:0];

  always_comb begin
    cmd         = '0;
    cmd.target  = holder_i;
    if (accept) begin
      case (req_type_i)
        REQ_RECORD: cmd.set     = wr_ok;
        REQ_REMOVE: cmd.clr     = wr_ok;
        REQ_CLEAR:  cmd.clr_all = 1'b1;
        default:    ;
      endcase
    end
  end

  wfd_table #(
    .ThreadCount(ThreadCount)
  ) u_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .wr_idx_i   (wr_idx),
    .rd_idx_i   (rd_idx),
    .rd_target_o(rd_target),
    .vld_idx_i  (cur_idx),
    .vld_o      (cur_vld)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cur_q   <= '0;
      req_q   <= '0;
      cnt_q   <= '0;
      seen_q  <= '0;
      done_q  <= 1'b0;
      dl_q    <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            dl_q <= 1'b0;
            if (req_type_i == REQ_CHECK) begin
              state_q <= ST_WALK;
              cur_q   <= holder_i;
              req_q   <= requester_i;
              cnt_q   <= '0;
              seen_q  <= '0;
            end else begin
              done_q <= 1'b1;
            end
          end
        end
        ST_WALK: begin
          // rd_target holds the entry of cur_q, read on the previous edge
          if (!cur_ok || seen_q[cur_idx] || !cur_vld) begin
            state_q <= ST_IDLE;
            done_q  <= 1'b1;
            dl_q    <= 1'b0;
          end else if (rd_target == req_q) begin
            state_q <= ST_IDLE;
            done_q  <= 1'b1;
            dl_q    <= 1'b1;
          end else if (cnt_q == CntW'(ThreadCount - 1)) begin
            state_q <= ST_IDLE;
            done_q  <= 1'b1;
            dl_q    <= 1'b0;
          end else begin
            seen_q[cur_idx] <= 1'b1;
            cur_q           <= rd_target;
            cnt_q           <= cnt_q + 1'b1;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign busy           = (state_q == ST_WALK);
  assign result_valid_o = done_q;
  assign deadlock_o     = dl_q;

  a_no_result_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !result_valid_o)
    else $error("result strobe during chain walk");

  a_edit_result_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && req_type_i != REQ_CHECK) |=> (result_valid_o && !deadlock_o))
    else $error("edit request did not give its result next cycle");

  a_check_walks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && req_type_i == REQ_CHECK) |=> busy)
    else $error("check request did not start a walk");

  a_deadlock_from_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && deadlock_o) |-> $past(busy))
    else $error("deadlock reported without a walk");

endmodule

[sim/wait_for_deadlock_detector_core_tb.sv]
// testbench for the wait-for deadlock detector: directed and random requests, scoreboard check
`timescale 1ns / 1ps

module wait_for_deadlock_detector_core_tb;
  import wfd_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int TailCycles = 2 * THREAD_COUNT_DEF + 4;

  // wait-for table predictor plus queue of expected verdicts
  class deadlock_scoreboard;
    bit                waiting [THREAD_COUNT_DEF];
    logic [SLOT_W-1:0] waits_on [THREAD_COUNT_DEF];
    bit                verdicts [$];
    int                mismatches;
    int                checks_done;
    int                edits_done;
    int                deadlocks_seen;
    int                longest_walk;

    function new();
      foreach (waiting[i]) waiting[i] = 1'b0;
      mismatches     = 0;
      checks_done    = 0;
      edits_done     = 0;
      deadlocks_seen = 0;
      longest_walk   = 0;
    endfunction

    // follow the chain from the holder, one entry per step
    function bit chain_reaches(logic [SLOT_W-1:0] asker, logic [SLOT_W-1:0] from_slot);
      bit [THREAD_COUNT_DEF-1:0] seen;
      logic [SLOT_W-1:0]         cur;
      seen = '0;
      cur  = from_slot;
      for (int step = 0; step < THREAD_COUNT_DEF; step++) begin
        if (seen[cur] || !waiting[cur]) begin
          if (step > longest_walk) longest_walk = step;
          return 1'b0;
        end
        seen[cur] = 1'b1;
        if (waits_on[cur] == asker) begin
          if (step + 1 > longest_walk) longest_walk = step + 1;
          return 1'b1;
        end
        cur = waits_on[cur];
      end
      longest_walk = THREAD_COUNT_DEF;
      return 1'b0;
    endfunction

    function void note_request(req_e kind, logic [SLOT_W-1:0] who, logic [SLOT_W-1:0] hold);
      bit verdict;
      verdict = 1'b0;
      case (kind)
        REQ_CHECK: begin
          verdict = chain_reaches(who, hold);
          checks_done++;
          if (verdict) deadlocks_seen++;
        end
        REQ_RECORD: begin
          waiting[who]  = 1'b1;
          waits_on[who] = hold;
          edits_done++;
        end
        REQ_REMOVE: begin
          waiting[who] = 1'b0;
          edits_done++;
        end
        default: begin
          foreach (waiting[i]) waiting[i] = 1'b0;
          edits_done++;
        end
      endcase
      verdicts = {verdicts, verdict};
    endfunction

    function void check_result(logic got);
      bit want;
      if (verdicts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with no request pending, deadlock=%b", $time, got);
        return;
      end
      want = verdicts.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: deadlock flag mismatch, expected %b got %b", $time, want, got);
      end
    endfunction

    function int pending();
      return verdicts.size();
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  logic [REQ_W-1:0]  req_type_i;
  logic [SLOT_W-1:0] requester_i;
  logic [SLOT_W-1:0] holder_i;
  logic              result_valid_o;
  logic              deadlock_o;

  deadlock_scoreboard sb = new();
  int                 sender_idle_pct;
  int                 items_sent;
  int                 cycle_count;

  wait_for_deadlock_detector_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .req_type_i    (req_type_i),
    .requester_i   (requester_i),
    .holder_i      (holder_i),
    .result_valid_o(result_valid_o),
    .deadlock_o    (deadlock_o)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("[wait_for_deadlock_detector_core] ERROR");
      $finish;
    end
  end

  // results first, then the item accepted at the same edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_valid_o) sb.check_result(deadlock_o);
      if (start && !busy) sb.note_request(req_e'(req_type_i), requester_i, holder_i);
    end
  end

  // entered and left at a falling edge; start stays high for a back-to-back item
  task automatic send_item(req_e kind, logic [SLOT_W-1:0] who, logic [SLOT_W-1:0] hold);
    bit taken;
    while ($urandom_range(99) < sender_idle_pct) begin
      start       <= 1'b0;
      req_type_i  <= REQ_W'($urandom);
      requester_i <= SLOT_W'($urandom);
      holder_i    <= SLOT_W'($urandom);
      @(negedge clk_i);
    end
    start       <= 1'b1;
    req_type_i  <= kind;
    requester_i <= who;
    holder_i    <= hold;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk_i);
      taken = !busy;
    end
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
  endtask

  // a permutation chain of random length, sometimes closed, then checks against it
  task automatic send_chain();
    int slots [THREAD_COUNT_DEF];
    int len;
    int j;
    int tmp;
    int n_checks;
    foreach (slots[i]) slots[i] = i;
    for (int i = THREAD_COUNT_DEF - 1; i > 0; i--) begin
      j        = $urandom_range(i, 0);
      tmp      = slots[i];
      slots[i] = slots[j];
      slots[j] = tmp;
    end
    len = $urandom_range(THREAD_COUNT_DEF, 2);
    if ($urandom_range(1)) send_item(REQ_CLEAR, SLOT_W'($urandom), SLOT_W'($urandom));
    for (int i = 0; i < len - 1; i++)
      send_item(REQ_RECORD, SLOT_W'(slots[i]), SLOT_W'(slots[i+1]));
    if ($urandom_range(2) == 0)
      send_item(REQ_RECORD, SLOT_W'(slots[len-1]), SLOT_W'(slots[$urandom_range(len-1, 0)]));
    n_checks = $urandom_range(5, 2);
    for (int i = 0; i < n_checks; i++) begin
      if ($urandom_range(3) == 0)
        send_item(REQ_CHECK, SLOT_W'($urandom), SLOT_W'(slots[$urandom_range(len-1, 0)]));
      else
        send_item(REQ_CHECK, SLOT_W'(slots[$urandom_range(len-1, 0)]),
                  SLOT_W'(slots[$urandom_range(len-1, 0)]));
    end
  endtask

  task automatic run_random(int n_items, int idle_pct);
    int stop_at;
    int pick;
    sender_idle_pct = idle_pct;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 45)      send_chain();
      else if (pick < 72) send_item(REQ_CHECK, SLOT_W'($urandom), SLOT_W'($urandom));
      else if (pick < 88) send_item(REQ_RECORD, SLOT_W'($urandom), SLOT_W'($urandom));
      else if (pick < 97) send_item(REQ_REMOVE, SLOT_W'($urandom), SLOT_W'($urandom));
      else                send_item(REQ_CLEAR, SLOT_W'($urandom), SLOT_W'($urandom));
    end
  endtask

  initial begin
    rst_ni          = 1'b0;
    start           = 1'b0;
    req_type_i      = REQ_CHECK;
    requester_i     = '0;
    holder_i        = '0;
    cycle_count     = 0;
    items_sent      = 0;
    sender_idle_pct = 0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // empty table, field extremes, remove with nothing to remove
    send_item(REQ_CHECK, 4'd0, 4'd0);
    send_item(REQ_CHECK, 4'd15, 4'd15);
    send_item(REQ_REMOVE, 4'd5, 4'd15);
    // two-thread cycle, holder equal to requester, loop that misses the requester
    send_item(REQ_RECORD, 4'd0, 4'd15);
    send_item(REQ_RECORD, 4'd15, 4'd0);
    send_item(REQ_CHECK, 4'd0, 4'd15);
    send_item(REQ_CHECK, 4'd15, 4'd15);
    send_item(REQ_CHECK, 4'd3, 4'd15);
    // overwrite a wait, then remove it
    send_item(REQ_RECORD, 4'd0, 4'd7);
    send_item(REQ_CHECK, 4'd15, 4'd15);
    send_item(REQ_CHECK, 4'd7, 4'd15);
    send_item(REQ_REMOVE, 4'd0, 4'd0);
    send_item(REQ_CHECK, 4'd7, 4'd15);
    send_item(REQ_CLEAR, 4'd15, 4'd15);
    send_item(REQ_CHECK, 4'd0, 4'd15);
    // three-thread loop
    send_item(REQ_RECORD, 4'd1, 4'd2);
    send_item(REQ_RECORD, 4'd2, 4'd3);
    send_item(REQ_RECORD, 4'd3, 4'd1);
    send_item(REQ_CHECK, 4'd9, 4'd1);
    send_item(REQ_CHECK, 4'd3, 4'd1);
    send_item(REQ_CHECK, 4'd1, 4'd1);
    send_item(REQ_CLEAR, 4'd0, 4'd0);
    drain();

    run_random(210, 33);
    drain();
    run_random(210, 76);
    drain();
    run_random(210, 0);
    drain();

    repeat (TailCycles) @(posedge clk_i);
    $display("run: %0d requests, %0d checks (%0d deadlocks), %0d table edits",
             items_sent, sb.checks_done, sb.deadlocks_seen, sb.edits_done);
    $display("longest chain walk %0d entries, %0d mismatches", sb.longest_walk, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("[wait_for_deadlock_detector_core] OK");
    end else begin
      $display("[wait_for_deadlock_detector_core] ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
sv/wfd_pkg.sv
sv/wfd_table.sv
sv/wait_for_deadlock_detector_core.sv
sim/wait_for_deadlock_detector_core_tb.sv
